@@ hw/rtl/tms_pkg.sv @@
// ----------------------------------------------------------------------------
// tms_pkg
// Types and codes shared by the Turing machine step engine modules.
// ----------------------------------------------------------------------------
package tms_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_TAPE_WR  = 3'd0,
    CMD_TAPE_RD  = 3'd1,
    CMD_HEADER   = 3'd2,
    CMD_MEMBER   = 3'd3,
    CMD_PRIM     = 3'd4,
    CMD_START    = 3'd5,
    CMD_STEP     = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  // run status codes
  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_FAIL   = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  // end kinds stored in a branch header
  localparam logic [1:0] END_CONT   = 2'd0;
  localparam logic [1:0] END_REJECT = 2'd2;

  // primitive kinds
  typedef enum logic [1:0] {
    PK_LEFT  = 2'd0,
    PK_RIGHT = 2'd1,
    PK_PRINT = 2'd2,
    PK_NOP   = 2'd3
  } prim_kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SYM,
    S_BRANCH,
    S_PRIM,
    S_SHOW_RD,
    S_SHOW_WAIT
  } fsm_e;

  localparam int SymbolCount = 256;

  // input transaction
  typedef struct packed {
    logic [2:0] command;
    logic [5:0] state_number;
    logic [1:0] branch_slot;
    logic [2:0] primitive_slot;
    logic [7:0] symbol_value;
    logic       member_flag;
    logic       default_flag;
    logic       branch_valid;
    logic [1:0] end_kind;
    logic [5:0] successor_state;
    logic [3:0] action_info;
    logic [9:0] tape_address;
  } tms_in_t;

  // result transaction
  typedef struct packed {
    logic [2:0] run_status;
    logic [5:0] state_out;
    logic [9:0] head_out;
    logic [7:0] symbol_out;
  } tms_out_t;

  // branch header word
  typedef struct packed {
    logic       valid;
    logic       dflt;
    logic [1:0] kind;
    logic [5:0] next;
    logic [3:0] count;
  } tms_hdr_t;

  // primitive word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sym;
  } tms_prim_t;

endpackage

@@ hw/rtl/turing_machine_step_engine.sv @@
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Command-driven engine that holds a Turing machine in on-chip tables and
// steps it over a bounded tape.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its tape, header and set
// memories through max(TAPE_LENGTH, 256 * STATE_COUNT * BRANCHES_PER_STATE)
// addresses (65536 at the defaults) with busy high. A command is taken when
// start is high and busy is low; each command gives exactly one result,
// shown for one cycle with done_o, which the receiver must take in that
// cycle. A step probes the branches of the current state in order and then
// runs the primitives of the branch that hit: every branch probe and every
// primitive is one read of the single-ported header, set and primitive
// memories.
module turing_machine_step_engine #(
  parameter int STATE_COUNT           = 64,
  parameter int BRANCHES_PER_STATE    = 4,
  parameter int PRIMITIVES_PER_BRANCH = 8,
  parameter int TAPE_LENGTH           = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tms_pkg::tms_in_t   item_i,
  output logic               done_o,
  output tms_pkg::tms_out_t  result_o
);
  import tms_pkg::*;

  localparam int BranchTotal = STATE_COUNT * BRANCHES_PER_STATE;
  localparam int PrimTotal   = BranchTotal * PRIMITIVES_PER_BRANCH;
  localparam int TW          = $clog2(TAPE_LENGTH);
  localparam int BIW         = $clog2(BranchTotal);
  localparam int SAW         = BIW + 8;
  localparam int PAW         = $clog2(PrimTotal);
  localparam int BW          = $clog2(BRANCHES_PER_STATE + 1);

  fsm_e              fsm_q, fsm_d;
  tms_in_t           item_q, item_d;
  logic [TW-1:0]     head_q, head_d;
  logic [5:0]        cur_q, cur_d;
  logic [2:0]        status_q, status_d;
  logic [7:0]        sym_q, sym_d;
  logic [BW-1:0]     br_q, br_d;
  logic [BIW-1:0]    hit_q, hit_d;
  tms_hdr_t          hdr_q, hdr_d;
  logic [3:0]        prim_q, prim_d;
  tms_out_t          res_q, res_d;
  logic              done_q, done_d;

  logic              clr_busy;
  logic              tape_we;
  logic [TW-1:0]     tape_waddr, tape_raddr;
  logic [7:0]        tape_wdata, tape_rdata;
  logic              hdr_we;
  logic [BIW-1:0]    hdr_addr;
  tms_hdr_t          hdr_wdata, hdr_rdata;
  logic              set_we, set_wdata, set_rdata;
  logic [SAW-1:0]    set_addr;
  logic              prim_we;
  logic [PAW-1:0]    prim_addr;
  tms_prim_t         prim_wdata, prim_rdata;

  logic              accept;
  logic              slot_ok, succ_ok, addr_ok, start_ok;
  logic [BIW-1:0]    load_bidx, probe_bidx;
  logic [BW-1:0]     probe_br;
  logic              br_hit, br_last, prim_stop, prim_last;
  logic [3:0]        prim_next;

  tms_store #(
    .TAPE_LENGTH  (TAPE_LENGTH),
    .BRANCH_TOTAL (BranchTotal),
    .PRIM_TOTAL   (PrimTotal)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_busy_o   (clr_busy),
    .tape_we_i    (tape_we),
    .tape_waddr_i (tape_waddr),
    .tape_wdata_i (tape_wdata),
    .tape_raddr_i (tape_raddr),
    .tape_rdata_o (tape_rdata),
    .hdr_we_i     (hdr_we),
    .hdr_addr_i   (hdr_addr),
    .hdr_wdata_i  (hdr_wdata),
    .hdr_rdata_o  (hdr_rdata),
    .set_we_i     (set_we),
    .set_addr_i   (set_addr),
    .set_wdata_i  (set_wdata),
    .set_rdata_o  (set_rdata),
    .prim_we_i    (prim_we),
    .prim_addr_i  (prim_addr),
    .prim_wdata_i (prim_wdata),
    .prim_rdata_o (prim_rdata)
  );

  assign accept = start && !busy;

  // decode of the held transaction and of the running step
  always_comb begin
    slot_ok   = (int'(item_q.state_number) < STATE_COUNT) &&
                (int'(item_q.branch_slot) < BRANCHES_PER_STATE);
    succ_ok   = int'(item_q.successor_state) < STATE_COUNT;
    addr_ok   = int'(item_q.tape_address) < TAPE_LENGTH;
    start_ok  = (int'(item_q.state_number) < STATE_COUNT) && addr_ok;
    load_bidx = BIW'(int'(item_q.state_number) * BRANCHES_PER_STATE +
                     int'(item_q.branch_slot));
    br_hit    = hdr_rdata.valid && (hdr_rdata.dflt || set_rdata);
    br_last   = br_q == BW'(BRANCHES_PER_STATE - 1);
    prim_next = prim_q + 4'd1;
    prim_last = prim_next == hdr_q.count;
    prim_stop = ((prim_rdata.kind == PK_LEFT) && (head_q == '0)) ||
                ((prim_rdata.kind == PK_RIGHT) &&
                 (int'(head_q) + 1 >= TAPE_LENGTH));
    probe_br  = (fsm_q == S_SYM) ? '0 : br_q + 1'b1;
    probe_bidx = BIW'(int'(cur_q) * BRANCHES_PER_STATE + int'(probe_br));
  end

  // next state
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_CLEAR: begin
        if (!clr_busy) fsm_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) fsm_d = S_EXEC;
      end
      S_EXEC: begin
        if ((cmd_e'(item_q.command) == CMD_STEP) && (status_q == ST_RUN)) begin
          fsm_d = S_SYM;
        end else begin
          fsm_d = S_SHOW_RD;
        end
      end
      S_SYM: fsm_d = S_BRANCH;
      S_BRANCH: begin
        if (br_hit) begin
          fsm_d = (hdr_rdata.count == 4'd0) ? S_SHOW_RD : S_PRIM;
        end else if (br_last) begin
          fsm_d = S_SHOW_RD;
        end
      end
      S_PRIM: begin
        if (prim_stop || prim_last) fsm_d = S_SHOW_RD;
      end
      S_SHOW_RD:   fsm_d = S_SHOW_WAIT;
      S_SHOW_WAIT: fsm_d = S_IDLE;
      default:     fsm_d = S_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    item_d     = item_q;
    head_d     = head_q;
    cur_d      = cur_q;
    status_d   = status_q;
    sym_d      = sym_q;
    br_d       = br_q;
    hit_d      = hit_q;
    hdr_d      = hdr_q;
    prim_d     = prim_q;
    res_d      = res_q;
    done_d     = 1'b0;
    busy       = (fsm_q != S_IDLE);
    tape_we    = 1'b0;
    tape_waddr = TW'(item_q.tape_address);
    tape_wdata = item_q.symbol_value;
    tape_raddr = head_q;
    hdr_we     = 1'b0;
    hdr_addr   = load_bidx;
    hdr_wdata  = '0;
    set_we     = 1'b0;
    set_addr   = {load_bidx, item_q.symbol_value};
    set_wdata  = item_q.member_flag;
    prim_we    = 1'b0;
    prim_addr  = PAW'(int'(load_bidx) * PRIMITIVES_PER_BRANCH +
                      int'(item_q.primitive_slot));
    prim_wdata = '0;

    case (fsm_q)
      S_IDLE: begin
        if (accept) item_d = item_i;
      end
      S_EXEC: begin
        case (cmd_e'(item_q.command))
          CMD_TAPE_WR: tape_we = addr_ok;
          CMD_HEADER: begin
            hdr_we          = slot_ok && succ_ok;
            hdr_wdata.valid = item_q.branch_valid;
            hdr_wdata.dflt  = item_q.default_flag;
            hdr_wdata.kind  = (item_q.end_kind > END_REJECT) ? END_REJECT
                                                              : item_q.end_kind;
            hdr_wdata.next  = item_q.successor_state;
            hdr_wdata.count = (int'(item_q.action_info) > PRIMITIVES_PER_BRANCH)
                              ? 4'(PRIMITIVES_PER_BRANCH) : item_q.action_info;
          end
          CMD_MEMBER: set_we = slot_ok;
          CMD_PRIM: begin
            prim_we         = slot_ok &&
                              (int'(item_q.primitive_slot) < PRIMITIVES_PER_BRANCH);
            prim_wdata.kind = (item_q.action_info > 4'(PK_PRINT)) ? PK_NOP
                              : item_q.action_info[1:0];
            prim_wdata.sym  = item_q.symbol_value;
          end
          CMD_START: begin
            if (start_ok) begin
              cur_d    = item_q.state_number;
              head_d   = TW'(item_q.tape_address);
              status_d = ST_RUN;
            end
          end
          CMD_TAPE_RD, CMD_STEP, CMD_NOP: begin
          end
          default: begin
          end
        endcase
      end
      // symbol under the head arrives, probe the first branch
      S_SYM: begin
        sym_d    = tape_rdata;
        br_d     = '0;
        hdr_addr = probe_bidx;
        set_addr = {probe_bidx, tape_rdata};
      end
      // branch search, one slot a cycle
      S_BRANCH: begin
        hdr_addr = probe_bidx;
        set_addr = {probe_bidx, sym_q};
        if (br_hit) begin
          hit_d     = BIW'(int'(cur_q) * BRANCHES_PER_STATE + int'(br_q));
          hdr_d     = hdr_rdata;
          prim_d    = 4'd0;
          prim_addr = PAW'(int'(cur_q) * BRANCHES_PER_STATE * PRIMITIVES_PER_BRANCH +
                           int'(br_q) * PRIMITIVES_PER_BRANCH);
          if (hdr_rdata.count == 4'd0) begin
            status_d = {1'b0, hdr_rdata.kind};
            if (hdr_rdata.kind == END_CONT) cur_d = hdr_rdata.next;
          end
        end else if (br_last) begin
          status_d = ST_FAIL;
        end else begin
          br_d = probe_br;
        end
      end
      // run one primitive a cycle
      S_PRIM: begin
        prim_addr  = PAW'(int'(hit_q) * PRIMITIVES_PER_BRANCH + int'(prim_next));
        tape_waddr = head_q;
        tape_wdata = prim_rdata.sym;
        if (prim_stop) begin
          status_d = ST_RANGE;
        end else begin
          case (prim_kind_e'(prim_rdata.kind))
            PK_LEFT:  head_d  = head_q - 1'b1;
            PK_RIGHT: head_d  = head_q + 1'b1;
            PK_PRINT: tape_we = 1'b1;
            PK_NOP:   begin
            end
            default:  begin
            end
          endcase
          prim_d = prim_next;
          if (prim_last) begin
            status_d = {1'b0, hdr_q.kind};
            if (hdr_q.kind == END_CONT) cur_d = hdr_q.next;
          end
        end
      end
      S_SHOW_RD: begin
        if (cmd_e'(item_q.command) == CMD_TAPE_RD) tape_raddr = TW'(item_q.tape_address);
      end
      // capture the result transaction
      S_SHOW_WAIT: begin
        done_d              = 1'b1;
        res_d.run_status    = status_q;
        res_d.state_out     = cur_q;
        res_d.head_out      = 10'(head_q);
        res_d.symbol_out    = ((cmd_e'(item_q.command) == CMD_TAPE_RD) && !addr_ok)
                              ? 8'd0 : tape_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= S_CLEAR;
      head_q   <= '0;
      cur_q    <= '0;
      status_q <= ST_RUN;
      done_q   <= 1'b0;
      br_q     <= '0;
      prim_q   <= '0;
    end else begin
      fsm_q    <= fsm_d;
      head_q   <= head_d;
      cur_q    <= cur_d;
      status_q <= status_d;
      done_q   <= done_d;
      br_q     <= br_d;
      prim_q   <= prim_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sym_q  <= sym_d;
    hit_q  <= hit_d;
    hdr_q  <= hdr_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // no transaction is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_CLEAR) |-> busy)
    else $error("accept possible during clearing pass");

  // results are never shown in back-to-back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // a result follows only a capture cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(fsm_q == S_SHOW_WAIT))
    else $error("result without capture");

  // status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q <= ST_RANGE)
    else $error("status code out of range");

  // a step on a stopped machine leaves state and head alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_EXEC && cmd_e'(item_q.command) == CMD_STEP && status_q != ST_RUN)
      |=> ($stable(cur_q) && $stable(head_q)))
    else $error("stopped machine changed");

endmodule

@@ hw/rtl/tms_store.sv @@
// ----------------------------------------------------------------------------
// tms_store
// Tape, branch header, symbol set and primitive memories with registered
// reads and a clearing pass over all but the primitive memory after reset.
// ----------------------------------------------------------------------------
module tms_store #(
  parameter int TAPE_LENGTH  = 1024,
  parameter int BRANCH_TOTAL = 256,
  parameter int PRIM_TOTAL   = 2048
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  output logic                                  clr_busy_o,
  input  logic                                  tape_we_i,
  input  logic [$clog2(TAPE_LENGTH)-1:0]        tape_waddr_i,
  input  logic [7:0]                            tape_wdata_i,
  input  logic [$clog2(TAPE_LENGTH)-1:0]        tape_raddr_i,
  output logic [7:0]                            tape_rdata_o,
  input  logic                                  hdr_we_i,
  input  logic [$clog2(BRANCH_TOTAL)-1:0]       hdr_addr_i,
  input  tms_pkg::tms_hdr_t                     hdr_wdata_i,
  output tms_pkg::tms_hdr_t                     hdr_rdata_o,
  input  logic                                  set_we_i,
  input  logic [$clog2(BRANCH_TOTAL)+7:0]       set_addr_i,
  input  logic                                  set_wdata_i,
  output logic                                  set_rdata_o,
  input  logic                                  prim_we_i,
  input  logic [$clog2(PRIM_TOTAL)-1:0]         prim_addr_i,
  input  tms_pkg::tms_prim_t                    prim_wdata_i,
  output tms_pkg::tms_prim_t                    prim_rdata_o
);
  import tms_pkg::*;

  localparam int TW       = $clog2(TAPE_LENGTH);
  localparam int BIW      = $clog2(BRANCH_TOTAL);
  localparam int SAW      = BIW + 8;
  localparam int SetDepth = BRANCH_TOTAL * SymbolCount;
  localparam int MaxDepth = (TAPE_LENGTH > SetDepth) ? TAPE_LENGTH : SetDepth;
  localparam int CLW      = $clog2(MaxDepth);

  logic [7:0]  tape_mem [TAPE_LENGTH];
  tms_hdr_t    hdr_mem  [BRANCH_TOTAL];
  logic        set_mem  [SetDepth];
  tms_prim_t   prim_mem [PRIM_TOTAL];

  logic [CLW-1:0] clr_q, clr_d;
  logic           clr_act_q, clr_act_d;

  // clearing pass counter
  always_comb begin
    clr_d     = clr_q;
    clr_act_d = clr_act_q;
    if (clr_act_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == CLW'(MaxDepth - 1)) begin
        clr_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      clr_act_q <= 1'b1;
    end else begin
      clr_q     <= clr_d;
      clr_act_q <= clr_act_d;
    end
  end

  assign clr_busy_o = clr_act_q;

  // tape memory
  always_ff @(posedge clk_i) begin
    if (clr_act_q) begin
      if (int'(clr_q) < TAPE_LENGTH) begin
        tape_mem[clr_q[TW-1:0]] <= '0;
      end
    end else if (tape_we_i) begin
      tape_mem[tape_waddr_i] <= tape_wdata_i;
    end
    tape_rdata_o <= tape_mem[tape_raddr_i];
  end

  // branch header memory
  always_ff @(posedge clk_i) begin
    if (clr_act_q) begin
      if (int'(clr_q) < BRANCH_TOTAL) begin
        hdr_mem[clr_q[BIW-1:0]] <= '0;
      end
    end else if (hdr_we_i) begin
      hdr_mem[hdr_addr_i] <= hdr_wdata_i;
    end
    hdr_rdata_o <= hdr_mem[hdr_addr_i];
  end

  // symbol set memory, one bit per branch and symbol
  always_ff @(posedge clk_i) begin
    if (clr_act_q) begin
      if (int'(clr_q) < SetDepth) begin
        set_mem[clr_q[SAW-1:0]] <= 1'b0;
      end
    end else if (set_we_i) begin
      set_mem[set_addr_i] <= set_wdata_i;
    end
    set_rdata_o <= set_mem[set_addr_i];
  end

  // primitive memory, contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (prim_we_i) begin
      prim_mem[prim_addr_i] <= prim_wdata_i;
    end
    prim_rdata_o <= prim_mem[prim_addr_i];
  end

endmodule

@@ dv/tms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_checker
// Watches the command and result channels of the Turing machine step engine,
// keeps its own copy of the machine tables and tape, predicts every result
// and compares it field by field against what the engine reports.
// ----------------------------------------------------------------------------
module tms_checker
  import tms_pkg::*;
#(
  parameter int STATE_COUNT           = 64,
  parameter int BRANCHES_PER_STATE    = 4,
  parameter int PRIMITIVES_PER_BRANCH = 8,
  parameter int TAPE_LENGTH           = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  tms_in_t  item_i,
  input  logic     done_i,
  input  tms_out_t result_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int BranchTotal = STATE_COUNT * BRANCHES_PER_STATE;

  // shadow copy of the engine's tables and registers
  logic [7:0] tape_mem [TAPE_LENGTH];
  tms_hdr_t   hdr_mem  [BranchTotal];
  logic [SymbolCount-1:0] set_mem [BranchTotal];
  tms_prim_t  prim_mem [BranchTotal][PRIMITIVES_PER_BRANCH];
  int         head_pos;
  int         cur_state;
  status_e    run_stat;

  tms_out_t expected_results [$];
  int       mismatches;

  initial begin
    for (int i = 0; i < TAPE_LENGTH; i++) tape_mem[i] = '0;
    for (int i = 0; i < BranchTotal; i++) begin
      hdr_mem[i] = '0;
      set_mem[i] = '0;
      for (int p = 0; p < PRIMITIVES_PER_BRANCH; p++) prim_mem[i][p] = '0;
    end
    head_pos   = 0;
    cur_state  = 0;
    run_stat   = ST_RUN;
    mismatches = 0;
  end

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  // one machine step on the shadow state
  function automatic void run_machine_step();
    int         hit;
    int         base;
    logic [7:0] sym;
    tms_hdr_t   h;
    tms_prim_t  q;
    if (run_stat != ST_RUN) return;
    sym  = tape_mem[head_pos];
    base = cur_state * BRANCHES_PER_STATE;
    hit  = -1;
    for (int b = 0; b < BRANCHES_PER_STATE; b++) begin
      if (hit < 0 && hdr_mem[base + b].valid &&
          (hdr_mem[base + b].dflt || set_mem[base + b][sym])) hit = base + b;
    end
    if (hit < 0) begin
      run_stat = ST_FAIL;
      return;
    end
    h = hdr_mem[hit];
    for (int p = 0; p < h.count && p < PRIMITIVES_PER_BRANCH; p++) begin
      q = prim_mem[hit][p];
      case (prim_kind_e'(q.kind))
        PK_LEFT: begin
          if (head_pos == 0) begin
            run_stat = ST_RANGE;
            return;
          end
          head_pos--;
        end
        PK_RIGHT: begin
          if (head_pos + 1 >= TAPE_LENGTH) begin
            run_stat = ST_RANGE;
            return;
          end
          head_pos++;
        end
        PK_PRINT: tape_mem[head_pos] = q.sym;
        default: ;
      endcase
    end
    run_stat = status_e'({1'b0, h.kind});
    if (h.kind == END_CONT) cur_state = h.next;
  endfunction

  // apply one command and work out the engine's answer
  function automatic tms_out_t engine_answer(tms_in_t it);
    int       bidx;
    tms_out_t r;
    bidx = it.state_number * BRANCHES_PER_STATE + it.branch_slot;
    case (cmd_e'(it.command))
      CMD_TAPE_WR: tape_mem[it.tape_address] = it.symbol_value;
      CMD_HEADER: begin
        hdr_mem[bidx].valid = it.branch_valid;
        hdr_mem[bidx].dflt  = it.default_flag;
        hdr_mem[bidx].kind  = (it.end_kind > END_REJECT) ? END_REJECT : it.end_kind;
        hdr_mem[bidx].next  = it.successor_state;
        hdr_mem[bidx].count = (it.action_info > PRIMITIVES_PER_BRANCH) ?
                              4'(PRIMITIVES_PER_BRANCH) : it.action_info;
      end
      CMD_MEMBER: set_mem[bidx][it.symbol_value] = it.member_flag;
      CMD_PRIM: begin
        prim_mem[bidx][it.primitive_slot].kind =
          (it.action_info > 4'(PK_PRINT)) ? PK_NOP : it.action_info[1:0];
        prim_mem[bidx][it.primitive_slot].sym = it.symbol_value;
      end
      CMD_START: begin
        cur_state = it.state_number;
        head_pos  = it.tape_address;
        run_stat  = ST_RUN;
      end
      CMD_STEP: run_machine_step();
      default: ;
    endcase
    r.run_status = run_stat;
    r.state_out  = 6'(cur_state);
    r.head_out   = 10'(head_pos);
    r.symbol_out = (it.command == CMD_TAPE_RD) ? tape_mem[it.tape_address]
                                                : tape_mem[head_pos];
    return r;
  endfunction

  // compare a finished transaction first, then record a newly accepted one
  always @(posedge clk_i) begin
    tms_out_t exp_r;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with nothing outstanding", $time);
        end else begin
          exp_r = expected_results.pop_front();
          if (result_i.run_status !== exp_r.run_status ||
              result_i.state_out  !== exp_r.state_out  ||
              result_i.head_out   !== exp_r.head_out   ||
              result_i.symbol_out !== exp_r.symbol_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp st=%0d q=%0d hd=%0d sym=%0d got st=%0d q=%0d hd=%0d sym=%0d",
                       $time, exp_r.run_status, exp_r.state_out, exp_r.head_out,
                       exp_r.symbol_out, result_i.run_status, result_i.state_out,
                       result_i.head_out, result_i.symbol_out);
          end
        end
      end
      if (start_i && !busy_i) expected_results.push_back(engine_answer(item_i));
    end
  end

  // anything still outstanding at the end is counted by the top
  final begin
  end

endmodule

@@ dv/tb_turing_machine_step_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turing_machine_step_engine
// Drives the step engine with a directed set of commands followed by random
// machine programs, tape traffic and steps in bursts; a checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_turing_machine_step_engine;
  import tms_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tms_in_t  item_i;
  logic     done_o;
  tms_out_t result_o;
  int       fail_count;
  int       pending;

  // which primitive slots have been loaded, per branch
  logic [7:0] prim_loaded [256];
  int         burst_left;
  int         steps_sent;
  int         items_sent;

  turing_machine_step_engine uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  tms_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit, well above the clearing pass plus every command at its slowest
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic tms_in_t mk(cmd_e c, int st, int bs, int ps, int sym, int mem,
                                 int dfl, int val, int endk, int succ, int act,
                                 int addr);
    tms_in_t it;
    it.command         = c;
    it.state_number    = 6'(st);
    it.branch_slot     = 2'(bs);
    it.primitive_slot  = 3'(ps);
    it.symbol_value    = 8'(sym);
    it.member_flag     = 1'(mem);
    it.default_flag    = 1'(dfl);
    it.branch_valid    = 1'(val);
    it.end_kind        = 2'(endk);
    it.successor_state = 6'(succ);
    it.action_info     = 4'(act);
    it.tape_address    = 10'(addr);
    return it;
  endfunction

  // present one transaction and hold it until the engine takes it
  task automatic send(tms_in_t it);
    logic taken;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start  <= 1'b1;
    item_i <= it;
    // busy is settled at the falling edge, before the edge that may take it
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    if (it.command == CMD_PRIM)
      prim_loaded[{it.state_number, it.branch_slot}][it.primitive_slot] = 1'b1;
    if (it.command == CMD_STEP) steps_sent++;
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic int pick_state();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 63);
  endfunction

  function automatic int pick_sym();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
  endfunction

  // random command, weighted toward programs that really run
  function automatic tms_in_t random_item();
    tms_in_t it;
    int      w;
    int      cnt;
    int      prefix;
    int      idx;
    it = tms_in_t'({$urandom, $urandom});
    w  = $urandom_range(0, 99);
    it.state_number = 6'(pick_state());
    it.symbol_value = 8'(pick_sym());
    if (w < 35) begin
      it.command = CMD_STEP;
    end else if (w < 43) begin
      it.command = CMD_START;
      it.tape_address = ($urandom_range(0, 4) == 0) ?
                        10'($urandom_range(0, 1023)) : 10'($urandom_range(505, 518));
    end else if (w < 55) begin
      it.command = CMD_TAPE_WR;
      if ($urandom_range(0, 2) != 0) it.tape_address = 10'($urandom_range(500, 523));
    end else if (w < 60) begin
      it.command = CMD_TAPE_RD;
    end else if (w < 70) begin
      it.command = CMD_HEADER;
      it.branch_valid    = ($urandom_range(0, 6) != 0);
      it.default_flag    = ($urandom_range(0, 9) < 3);
      it.end_kind        = ($urandom_range(0, 9) < 7) ? END_CONT : 2'($urandom_range(1, 3));
      it.successor_state = 6'(pick_state());
      idx    = {it.state_number, it.branch_slot};
      prefix = 0;
      while (prefix < 8 && prim_loaded[idx][prefix]) prefix++;
      cnt = $urandom_range(0, 15);
      if (!(cnt > 8 && prefix == 8) && cnt > prefix) cnt = prefix;
      it.action_info = 4'(cnt);
    end else if (w < 82) begin
      it.command = CMD_MEMBER;
    end else if (w < 97) begin
      it.command = CMD_PRIM;
      if ($urandom_range(0, 5) != 0) it.action_info = 4'($urandom_range(0, 3));
    end else begin
      it.command = CMD_NOP;
    end
    return it;
  endfunction

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    burst_left = 0;
    steps_sent = 0;
    items_sent = 0;
    for (int i = 0; i < 256; i++) prim_loaded[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: tape extremes, every command, reject, no-branch and range stops
    send(mk(CMD_TAPE_WR, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0, 1023));
    send(mk(CMD_TAPE_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
    send(mk(CMD_PRIM, 0, 0, 0, 0, 0, 0, 0, 0, 0, PK_RIGHT, 0));
    send(mk(CMD_PRIM, 0, 0, 1, 8'hAA, 0, 0, 0, 0, 0, PK_PRINT, 0));
    send(mk(CMD_PRIM, 0, 0, 2, 0, 0, 0, 0, 0, 0, 15, 0));
    send(mk(CMD_PRIM, 0, 0, 3, 0, 0, 0, 0, 0, 0, PK_LEFT, 0));
    send(mk(CMD_MEMBER, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_MEMBER, 0, 1, 0, 255, 1, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_MEMBER, 0, 1, 0, 255, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_HEADER, 0, 0, 0, 0, 0, 0, 1, 0, 1, 3, 0));
    send(mk(CMD_HEADER, 1, 3, 0, 0, 0, 1, 1, 3, 63, 0, 0));
    send(mk(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_START, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_PRIM, 62, 0, 0, 0, 0, 0, 0, 0, 0, PK_LEFT, 0));
    send(mk(CMD_HEADER, 62, 0, 0, 0, 0, 1, 1, 1, 0, 1, 0));
    send(mk(CMD_START, 62, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_PRIM, 63, 3, 7, 0, 0, 0, 0, 0, 0, PK_RIGHT, 0));
    send(mk(CMD_PRIM, 63, 3, 0, 0, 0, 0, 0, 0, 0, PK_RIGHT, 0));
    send(mk(CMD_HEADER, 63, 3, 0, 0, 0, 1, 1, 0, 63, 1, 0));
    send(mk(CMD_START, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
    send(mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_NOP, 63, 3, 7, 255, 1, 1, 1, 3, 63, 15, 1023));
    drain();

    // random phases, each followed by a full drain
    for (int ph = 0; ph < 6; ph++) begin
      repeat (225) send(random_item());
      drain();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d commands, %0d of them machine steps", items_sent, steps_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tms_pkg.sv
hw/rtl/tms_store.sv
hw/rtl/turing_machine_step_engine.sv
dv/tms_checker.sv
dv/tb_turing_machine_step_engine.sv
